/* hdl/grr_pkg.sv */
package grr_pkg;

  localparam int unsigned MAX_GROUP = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned ADDR_W    = $clog2(MAX_GROUP);
  localparam int unsigned CNT_W     = $clog2(MAX_GROUP + 1);
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [CFG_W-1:0]  GROUP_SIZE_RST = CFG_W'(2);
  localparam logic [APB_AW-1:0] REG_GROUP_SIZE = APB_AW'(0);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } grr_state_e;

  // Group size clamped to 1..MAX_GROUP
  function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] size);
    logic [CNT_W-1:0] s;
    if (size == '0) begin
      s = CNT_W'(1);
    end else if (32'(size) > MAX_GROUP) begin
      s = CNT_W'(MAX_GROUP);
    end else begin
      s = CNT_W'(size);
    end
    return s;
  endfunction

endpackage

/* hdl/grr_in_if.sv */
interface grr_in_if;
  import grr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     end_of_sequence;

  modport source (output valid, output value, output end_of_sequence, input ready);
  modport sink   (input valid, input value, input end_of_sequence, output ready);
endinterface

/* hdl/grr_out_if.sv */
interface grr_out_if;
  import grr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value_res;
  logic                     last_of_run;
  logic                     last_of_sequence;

  modport source (output valid, output value_res, output last_of_run,
                  output last_of_sequence, input ready);
  modport sink   (input valid, input value_res, input last_of_run,
                  input last_of_sequence, output ready);
endinterface

/* hdl/group_reverse_reorder.sv */
// An item that completes a group, or ends the sequence, starts an emission: each
// result is read from the buffer RAM (ST_READ) and then loaded into the output
// register (ST_LOAD); the load waits while the sink stalls.
// Throughput: 1 item per cycle while nothing is emitted; an emitting item stalls input
// until its last result loads, as the single RAM read port is walked entry by entry.
// Reset: group size to 2, fill count and output valid clear; buffer RAM not cleared.
module group_reverse_reorder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  grr_in_if.sink                      in_i,
  grr_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [grr_pkg::APB_AW-1:0]  paddr,
  input  logic [grr_pkg::APB_DW-1:0]  pwdata,
  output logic [grr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import grr_pkg::*;

  grr_state_e        state_q, state_d;
  logic [CFG_W-1:0]  group_size_q;
  logic [ADDR_W-1:0] fill_q, fill_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic              rev_q, rev_d;
  logic              eos_q, eos_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q;
  logic              out_lor_q, out_los_q;

  logic              in_fire, out_fire, ld, cfg_wr;
  logic [CNT_W-1:0]  fill_new, size_eff;
  logic              emit;
  logic              ram_re;
  logic [DATA_W-1:0] ram_rdata;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_GROUP_SIZE[APB_AW-1:2]);

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1:2] == REG_GROUP_SIZE[APB_AW-1:2]) begin
      prdata = APB_DW'(group_size_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= GROUP_SIZE_RST;
    end else if (cfg_wr) begin
      group_size_q <= pwdata[CFG_W-1:0];
    end
  end

  // ---------------- input side ----------------
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign fill_new   = CNT_W'(fill_q) + CNT_W'(1);
  assign size_eff   = eff_size(group_size_q);
  assign emit       = (fill_new >= size_eff) || in_i.end_of_sequence;

  // fill_new never exceeds MAX_GROUP, and a full buffer always meets the size
  assign fill_d = (in_fire && emit) ? '0 :
                  in_fire           ? fill_new[ADDR_W-1:0] : fill_q;

  grr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_GROUP)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (fill_q),
    .wdata_i (in_i.value),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // ---------------- emit sequencer ----------------
  assign ld       = (state_q == ST_LOAD) && (!out_valid_q || out_o.ready);
  assign out_fire = out_o.valid && out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire && emit) state_d = ST_READ;
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: begin
        if (ld) begin
          state_d = (left_q == CNT_W'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_re = (state_q == ST_READ);
    addr_d = addr_q;
    left_d = left_q;
    rev_d  = rev_q;
    eos_d  = eos_q;
    if (in_fire && emit) begin
      // reverse starts at the newest entry, arrival order at entry zero
      rev_d  = (fill_new >= size_eff);
      addr_d = (fill_new >= size_eff) ? fill_q : '0;
      left_d = fill_new;
      eos_d  = in_i.end_of_sequence;
    end else if (ld) begin
      left_d = left_q - CNT_W'(1);
      addr_d = rev_q ? addr_q - ADDR_W'(1) : addr_q + ADDR_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ld) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    rev_q  <= rev_d;
    eos_q  <= eos_d;
    if (ld) begin
      out_value_q <= ram_rdata;
      out_lor_q   <= (left_q == CNT_W'(1));
      out_los_q   <= (left_q == CNT_W'(1)) && eos_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.value_res        = signed'(out_value_q);
  assign out_o.last_of_run      = out_lor_q;
  assign out_o.last_of_sequence = out_los_q;

`ifndef NO_ASSERTIONS
  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (left_q != '0))
    else $error("emit sequencer active with no results left");

  a_eos_clears_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.end_of_sequence) |=> (fill_q == '0))
    else $error("fill count not cleared after end of sequence");

  a_los_implies_lor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_o.last_of_sequence |-> out_o.last_of_run)
    else $error("last_of_sequence without last_of_run");

  a_load_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_LOAD))
    else $error("read data not loaded");

  a_no_write_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_fire)
    else $error("buffer written during emission");
`endif

endmodule

/* hdl/grr_ram.sv */
module grr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
